>>> design/doorbell_queue_scheduler_assert.svh
// Assertion macros for the doorbell queue scheduler checker.
// Needs nothing; the including module provides i_clk and i_rst_n.
`ifndef DOORBELL_QUEUE_SCHEDULER_ASSERT_SVH
`define DOORBELL_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define DQS_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("dqs assertion failed");

// next-cycle implication
`define DQS_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("dqs assertion failed");

`endif

>>> design/dqs_pkg.sv
// Shared types and codes of the doorbell queue scheduler.
// No dependencies.
package dqs_pkg;

    localparam logic [1:0] FN_DOORBELL = 2'd0;
    localparam logic [1:0] FN_SELECT   = 2'd1;
    localparam logic [1:0] FN_CONSUME  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_TYPE  = 2'd1;
    localparam logic [1:0] STS_BAD_QUEUE = 2'd2;
    localparam logic [1:0] STS_EMPTY     = 2'd3;

    localparam logic CFG_CONTROL_TYPE = 1'b0;
    localparam logic CFG_BURST_LIMIT  = 1'b1;

    localparam logic [15:0] BURST_RESET = 16'd32;

    // counter update broadcast to every cell
    typedef struct packed {
        logic        en;
        logic        sub;
        logic [7:0]  idx;
        logic [15:0] amt;
    } t_upd;

    // search token moving along the ring
    typedef struct packed {
        logic       valid;
        logic [7:0] hops;
    } t_tok;

    // per-cell search outcome, all zero unless this cell ends the search
    typedef struct packed {
        logic        claim;
        logic        empty;
        logic [7:0]  idx;
        logic [31:0] value;
    } t_cres;

endpackage

>>> design/dqs_req_if.sv
// Request channel of the doorbell queue scheduler.
// No dependencies.
interface dqs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  message_type;
    logic [7:0]  queue_index;
    logic [15:0] packet_count;

    modport source (output valid, func, message_type, queue_index, packet_count,
                    input ready);
    modport sink   (input valid, func, message_type, queue_index, packet_count,
                    output ready);
endinterface

>>> design/dqs_rsp_if.sv
// Result channel of the doorbell queue scheduler.
// No dependencies.
interface dqs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  granted_queue;
    logic [15:0] grant_count;

    modport source (output valid, status, granted_queue, grant_count, input ready);
    modport sink   (input valid, status, granted_queue, grant_count, output ready);
endinterface

>>> design/doorbell_queue_scheduler.sv
// Doorbell queue scheduler: signed pending counters per queue, round-robin grant.
// Depends on dqs_pkg, dqs_req_if, dqs_rsp_if and dqs_cell.
//
// Usage:
//   i_req carries one item per valid/ready handshake: func 0 doorbell (adds
//   packet_count to queue_index if message_type matches the control type),
//   func 1 select, func 2 consume (subtracts packet_count). o_rsp returns
//   exactly one result per item, in order, from an output register.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data while idle:
//   index 0 control type code, index 1 burst limit.
//   Doorbell, consume and unused codes load the result register at the accept
//   and pass it to the output register from S_DONE. A select sends a token
//   around the cell ring, one cell per cycle, starting at the scan pointer;
//   the granting cell, or the last cell of an empty scan, reports in S_SCAN.
//   One item at a time; i_req.ready returns in the same cycle that the result
//   is loaded into the output register.
//   The output register keeps a result while o_rsp.ready is low; the next
//   item may already be accepted, but its result waits in the block.
//   Reset (synchronous, active low) zeroes all counters and the pointer and
//   loads the configuration reset values.
module doorbell_queue_scheduler #(
    parameter int QUEUE_COUNT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    dqs_req_if.sink            i_req,
    dqs_rsp_if.source          o_rsp
);
    import dqs_pkg::*;

    localparam int PW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state      r_state;
    logic [7:0]  r_ctl_type;
    logic [15:0] r_burst;
    logic [PW-1:0] r_ptr;
    logic [1:0]  r_res_status;
    logic [7:0]  r_res_queue;
    logic [15:0] r_res_count;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_queue;
    logic [15:0] r_out_count;

    logic        w_fire;
    logic        w_in_range;
    logic        w_type_ok;
    logic [1:0]  w_status;
    t_upd        w_upd;
    t_cres       w_any;
    logic [15:0] w_cap;
    t_tok        c_tok [QUEUE_COUNT];
    t_cres       c_res [QUEUE_COUNT];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_fire      = i_req.valid && (r_state == S_IDLE);
    assign w_in_range  = ({1'b0, i_req.queue_index} < 9'(QUEUE_COUNT));
    assign w_type_ok   = (i_req.message_type == r_ctl_type);

    always_comb begin
        w_upd.en  = w_fire && w_in_range &&
                    (((i_req.func == FN_DOORBELL) && w_type_ok) ||
                     (i_req.func == FN_CONSUME));
        w_upd.sub = (i_req.func == FN_CONSUME);
        w_upd.idx = i_req.queue_index;
        w_upd.amt = i_req.packet_count;
    end

    always_comb begin
        unique case (i_req.func)
            FN_DOORBELL: begin
                if (!w_type_ok) begin
                    w_status = STS_BAD_TYPE;
                end else if (!w_in_range) begin
                    w_status = STS_BAD_QUEUE;
                end else begin
                    w_status = STS_OK;
                end
            end
            FN_CONSUME: w_status = w_in_range ? STS_OK : STS_BAD_QUEUE;
            default:    w_status = STS_OK;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_COUNT; gi++) begin : g_cell
            localparam int PREV = (gi == 0) ? QUEUE_COUNT - 1 : gi - 1;
            dqs_cell #(
                .QUEUE_COUNT (QUEUE_COUNT),
                .CELL_ID     (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_upd   (w_upd),
                .i_start (w_fire && (i_req.func == FN_SELECT) &&
                          (r_ptr == PW'(gi))),
                .i_tok   (c_tok[PREV]),
                .o_tok   (c_tok[gi]),
                .o_res   (c_res[gi])
            );
        end
    endgenerate

    // at most one cell reports per cycle
    always_comb begin
        w_any = '0;
        for (int k = 0; k < QUEUE_COUNT; k++) begin
            w_any = w_any | c_res[k];
        end
    end

    assign w_cap = (w_any.value > {16'd0, r_burst}) ? r_burst : w_any.value[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctl_type  <= 8'd0;
            r_burst     <= BURST_RESET;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CONTROL_TYPE: r_ctl_type <= i_cfg_data[7:0];
                    CFG_BURST_LIMIT:  r_burst    <= i_cfg_data;
                endcase
            end
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_fire) begin
                        r_res_status <= w_status;
                        r_res_queue  <= 8'd0;
                        r_res_count  <= 16'd0;
                        r_state      <= (i_req.func == FN_SELECT) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_any.claim) begin
                        r_ptr        <= w_any.idx[PW-1:0];
                        r_res_status <= STS_OK;
                        r_res_queue  <= w_any.idx;
                        r_res_count  <= w_cap;
                        r_state      <= S_DONE;
                    end else if (w_any.empty) begin
                        r_res_status <= STS_EMPTY;
                        r_res_queue  <= 8'd0;
                        r_res_count  <= 16'd0;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_queue  <= r_res_queue;
                        r_out_count  <= r_res_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_queue = r_out_queue;
    assign o_rsp.grant_count   = r_out_count;

endmodule

>>> design/dqs_cell.sv
// One queue cell: pending counter plus one hop of the round-robin search ring.
// Depends on dqs_pkg.
module dqs_cell #(
    parameter int QUEUE_COUNT = 32,
    parameter int CELL_ID     = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dqs_pkg::t_upd i_upd,
    input  logic          i_start,
    input  dqs_pkg::t_tok i_tok,
    output dqs_pkg::t_tok o_tok,
    output dqs_pkg::t_cres o_res
);
    import dqs_pkg::*;

    logic [31:0] r_cnt;
    t_tok        r_tok;
    t_cres       r_res;
    t_tok        w_tin;
    t_tok        n_tok;
    t_cres       n_res;
    logic        w_pos;
    logic        w_last;

    assign w_pos  = (r_cnt != 32'd0) && !r_cnt[31];
    assign w_tin  = i_start ? t_tok'{valid: 1'b1, hops: 8'd0} : i_tok;
    assign w_last = (w_tin.hops == 8'(QUEUE_COUNT - 1));

    always_comb begin
        n_tok.valid = w_tin.valid && !w_pos && !w_last;
        n_tok.hops  = w_tin.hops + 8'd1;
        n_res.claim = w_tin.valid && w_pos;
        n_res.empty = w_tin.valid && !w_pos && w_last;
        n_res.idx   = n_res.claim ? 8'(CELL_ID) : 8'd0;
        n_res.value = n_res.claim ? r_cnt : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 32'd0;
            r_tok <= '0;
            r_res <= '0;
        end else begin
            r_tok <= n_tok;
            r_res <= n_res;
            if (i_upd.en && (i_upd.idx == 8'(CELL_ID))) begin
                if (i_upd.sub) begin
                    r_cnt <= r_cnt - {16'd0, i_upd.amt};
                end else begin
                    r_cnt <= r_cnt + {16'd0, i_upd.amt};
                end
            end
        end
    end

    assign o_tok = r_tok;
    assign o_res = r_res;

endmodule

>>> design/dqs_checker.sv
// Port-level checks of the doorbell queue scheduler, bound to the top level.
// Depends on dqs_pkg and doorbell_queue_scheduler_assert.svh.
`include "doorbell_queue_scheduler_assert.svh"

module dqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [1:0]  i_req_func,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [7:0]  i_rsp_queue,
    input logic [15:0] i_rsp_count
);
    import dqs_pkg::*;

    logic [1:0] r_pend;
    logic [1:0] n_pend;
    logic [1:0] r_last_func;
    logic       w_in_fire;
    logic       w_out_fire;

    assign w_in_fire  = i_req_valid && i_req_ready;
    assign w_out_fire = i_rsp_valid && i_rsp_ready;

    always_comb begin
        n_pend = r_pend;
        if (w_in_fire && !w_out_fire) begin
            n_pend = r_pend + 2'd1;
        end else if (!w_in_fire && w_out_fire) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 2'd0;
            r_last_func <= FN_DOORBELL;
        end else begin
            r_pend <= n_pend;
            if (w_in_fire) begin
                r_last_func <= i_req_func;
            end
        end
    end

    `DQS_ASSERT_NEXT(a_busy_after_item, w_in_fire, !i_req_ready)

    `DQS_ASSERT_NOW(a_one_in_flight, 1'b1, r_pend <= 2'd2 && !(r_pend == 2'd2 && !i_rsp_valid))

    `DQS_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_queue) && $stable(i_rsp_count))

    `DQS_ASSERT_NOW(a_empty_zero, i_rsp_valid && i_rsp_status == STS_EMPTY, i_rsp_queue == 8'd0 && i_rsp_count == 16'd0)

    `DQS_ASSERT_NOW(a_no_grant_other, i_rsp_valid && r_pend == 2'd1 && r_last_func != FN_SELECT, i_rsp_queue == 8'd0 && i_rsp_count == 16'd0)

endmodule

bind doorbell_queue_scheduler dqs_checker u_dqs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_func   (i_req.func),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_queue  (o_rsp.granted_queue),
    .i_rsp_count  (o_rsp.grant_count)
);

>>> tb/sv/doorbell_queue_scheduler_tb.sv
// Self-checking testbench for doorbell_queue_scheduler: directed and random items
// against a built-in predictor of the counters and round-robin pointer.
// Depends on dqs_pkg, dqs_req_if, dqs_rsp_if and the scheduler RTL.
`timescale 1ns / 100ps

module doorbell_queue_scheduler_tb;
    import dqs_pkg::*;

    localparam int QCOUNT = 32;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RSP_HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 192;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  queue;
        logic [15:0] count;
    } t_sched_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    dqs_req_if req_if ();
    dqs_rsp_if rsp_if ();

    doorbell_queue_scheduler #(
        .QUEUE_COUNT(QCOUNT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // predictor state
    logic [31:0] pend_cnt [QCOUNT];
    logic [4:0]  rr_ptr;
    logic [7:0]  ctl_type;
    logic [15:0] burst_lim;

    t_sched_outcome outcome_q [$];
    int err_count = 0;
    bit gaps_on = 1'b1;
    bit rsp_hold_req = 1'b0;
    bit rsp_holding = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_model();
        for (int k = 0; k < QCOUNT; k++) pend_cnt[k] = '0;
        rr_ptr = '0;
        ctl_type = '0;
        burst_lim = BURST_RESET;
    endfunction

    function automatic t_sched_outcome schedule_item(input logic [1:0] f, input logic [7:0] mt,
                                                     input logic [7:0] qi, input logic [15:0] pc);
        t_sched_outcome res;
        logic [31:0] v;
        int pos;
        bit found;
        res = '0;
        res.status = STS_OK;
        found = 1'b0;
        case (f)
            FN_DOORBELL: begin
                if (mt != ctl_type) res.status = STS_BAD_TYPE;
                else if (qi >= QCOUNT) res.status = STS_BAD_QUEUE;
                else pend_cnt[qi] = pend_cnt[qi] + {16'd0, pc};
            end
            FN_SELECT: begin
                for (int k = 0; k < QCOUNT && !found; k++) begin
                    pos = (int'(rr_ptr) + k) % QCOUNT;
                    v = pend_cnt[pos];
                    if (v != 0 && !v[31]) begin
                        found = 1'b1;
                        rr_ptr = 5'(pos);
                        res.queue = 8'(pos);
                        res.count = (v > {16'd0, burst_lim}) ? burst_lim : v[15:0];
                    end
                end
                if (!found) res.status = STS_EMPTY;
            end
            FN_CONSUME: begin
                if (qi >= QCOUNT) res.status = STS_BAD_QUEUE;
                else pend_cnt[qi] = pend_cnt[qi] - {16'd0, pc};
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_request(input logic [1:0] f, input logic [7:0] mt,
                                 input logic [7:0] qi, input logic [15:0] pc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.message_type <= mt;
        req_if.queue_index  <= qi;
        req_if.packet_count <= pc;
        do @(posedge i_clk); while (!req_if.ready);
        outcome_q.push_back(schedule_item(f, mt, qi, pc));
    endtask

    task automatic drain_block();
        req_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CONTROL_TYPE) ctl_type = data[7:0];
        else burst_lim = data;
    endtask

    task automatic test_defaults();
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        issue_request(FN_DOORBELL, 8'h00, 8'd0, 16'd0);
        issue_request(FN_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
        issue_request(FN_CONSUME, 8'h00, 8'd0, 16'd0);
    endtask

    task automatic test_doorbell_errors();
        drain_block();
        write_reg(CFG_CONTROL_TYPE, 16'h00A5);
        issue_request(FN_DOORBELL, 8'h5A, 8'd3, 16'd7);
        issue_request(FN_DOORBELL, 8'h5A, 8'd255, 16'd7);   // type wins over queue
        issue_request(FN_DOORBELL, 8'hA5, 8'd32, 16'd7);
        issue_request(FN_DOORBELL, 8'hA5, 8'd255, 16'hFFFF);
        issue_request(FN_CONSUME, 8'h00, 8'd32, 16'd1);
        issue_request(FN_CONSUME, 8'h00, 8'd128, 16'd1);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
    endtask

    task automatic test_round_robin();
        issue_request(FN_DOORBELL, 8'hA5, 8'd31, 16'hFFFF);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        issue_request(FN_DOORBELL, 8'hA5, 8'd0, 16'd5);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);       // pointer stays on 31
        issue_request(FN_CONSUME, 8'h00, 8'd31, 16'hFFFF);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);       // wraps to 0
        issue_request(FN_CONSUME, 8'h00, 8'd0, 16'd10);     // goes negative
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        issue_request(FN_DOORBELL, 8'hA5, 8'd0, 16'd5);
    endtask

    task automatic test_burst_limits();
        drain_block();
        write_reg(CFG_BURST_LIMIT, 16'hFFFF);
        issue_request(FN_DOORBELL, 8'hA5, 8'd7, 16'hFFFF);
        issue_request(FN_DOORBELL, 8'hA5, 8'd7, 16'hFFFF);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        drain_block();
        write_reg(CFG_BURST_LIMIT, 16'd1);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        drain_block();
        write_reg(CFG_BURST_LIMIT, 16'd0);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
        drain_block();
        write_reg(CFG_CONTROL_TYPE, 16'h00FF);
        issue_request(FN_DOORBELL, 8'hFF, 8'd16, 16'd1);
        issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
    endtask

    task automatic test_backpressure();
        drain_block();
        write_reg(CFG_BURST_LIMIT, 16'd32);
        rsp_hold_req = 1'b1;
        wait (rsp_holding);
        gaps_on = 1'b0;
        for (int n = 0; n < 16; n++) begin
            if (n % 3 == 2) issue_request(FN_SELECT, 8'h00, 8'd0, 16'd0);
            else issue_request(FN_DOORBELL, ctl_type, 8'($urandom_range(0, QCOUNT - 1)),
                               16'($urandom_range(1, 64)));
        end
        gaps_on = 1'b1;
        drain_block();
    endtask

    task automatic test_random_traffic();
        int r;
        logic [1:0]  f;
        logic [7:0]  mt;
        logic [7:0]  qi;
        logic [15:0] pc;
        logic [15:0] burst_pick;
        for (int phase = 0; phase < 6; phase++) begin
            drain_block();
            case (phase)
                0: write_reg(CFG_CONTROL_TYPE, 16'h0000);
                1: write_reg(CFG_CONTROL_TYPE, 16'h00FF);
                default: write_reg(CFG_CONTROL_TYPE, 16'($urandom_range(0, 255)));
            endcase
            case (phase)
                0: burst_pick = 16'd1;
                1: burst_pick = 16'hFFFF;
                2: burst_pick = 16'd0;
                default: burst_pick = 16'($urandom_range(1, 64));
            endcase
            write_reg(CFG_BURST_LIMIT, burst_pick);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
                r  = $urandom_range(0, 99);
                f  = FN_SELECT;
                mt = ctl_type;
                qi = 8'($urandom_range(0, QCOUNT - 1));
                pc = 16'($urandom_range(1, 48));
                if (r < 35) begin
                    f = FN_DOORBELL;
                end else if (r < 60) begin
                    f = FN_SELECT;
                end else if (r < 80) begin
                    // consume from the queue most recently granted
                    f  = FN_CONSUME;
                    qi = 8'(rr_ptr);
                    pc = 16'($urandom_range(0, 40));
                end else begin
                    f  = 2'($urandom_range(0, 3));
                    mt = 8'($urandom);
                    qi = 8'($urandom);
                    pc = 16'($urandom);
                end
                if ($urandom_range(0, 19) == 0) pc = 16'($urandom);
                issue_request(f, mt, qi, pc);
            end
        end
        gaps_on = 1'b1;
    endtask

    // result sink pacing
    initial begin : rsp_pacing
        int n;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold_req) begin
                rsp_holding = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge i_clk);
                rsp_holding = 1'b0;
                rsp_hold_req = 1'b0;
            end else begin
                n = pick_stall();
                if (n > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                rsp_if.ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
                repeat (n) begin
                    @(posedge i_clk);
                    if (rsp_hold_req) break;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sched_outcome exp_res;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: status %0d queue %0d count %0d",
                       rsp_if.status, rsp_if.granted_queue, rsp_if.grant_count);
                err_count++;
            end else begin
                exp_res = outcome_q.pop_front();
                if (rsp_if.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, rsp_if.status);
                    err_count++;
                end
                if (rsp_if.granted_queue !== exp_res.queue) begin
                    $error("granted_queue: expected %0d, got %0d",
                           exp_res.queue, rsp_if.granted_queue);
                    err_count++;
                end
                if (rsp_if.grant_count !== exp_res.count) begin
                    $error("grant_count: expected %0d, got %0d",
                           exp_res.count, rsp_if.grant_count);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("doorbell_queue_scheduler_tb: FAIL");
        $finish;
    end

    initial begin : run_tests
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= 1'b0;
        i_cfg_data          <= '0;
        req_if.valid        <= 1'b0;
        req_if.func         <= FN_DOORBELL;
        req_if.message_type <= '0;
        req_if.queue_index  <= '0;
        req_if.packet_count <= '0;
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_doorbell_errors();
        test_round_robin();
        test_burst_limits();
        test_backpressure();
        test_random_traffic();

        drain_block();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("doorbell_queue_scheduler_tb: PASS");
        end else begin
            $display("doorbell_queue_scheduler_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/dqs_pkg.sv
design/dqs_req_if.sv
design/dqs_rsp_if.sv
design/dqs_cell.sv
design/doorbell_queue_scheduler.sv
design/dqs_checker.sv
tb/sv/doorbell_queue_scheduler_tb.sv
